/* rtl/core/pbfa_pkg.sv */
// shared types and constants of the packed bit field array
`default_nettype none

package pbfa_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	localparam int WIDTH_W = 7;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 15;
	localparam int VALUE_W = 64;
	localparam int CFG_W   = 16;
	localparam int BASE_W  = INDEX_W + WIDTH_W;
	localparam int LAST_W  = BASE_W + 1;
	localparam int LBYTE_W = LAST_W - 3;
	localparam int WIN_W   = VALUE_W + 8;
	localparam int SPAN    = 9;
	localparam int STEP_W  = 4;

	// register indexes of the configuration port
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic {
		FUNC_READ  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_RUN,
		ST_FIN
	} state_t;

	// low bit masks for 1..8 bits
	localparam logic [7:0] LOW_MASK [8] = '{
		8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
	};

	typedef struct packed {
		logic load;
		logic issue;
		logic consume;
		logic is_write;
	} lane_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/pbfa_if.sv */
// request and result channels of the packed bit field array
`default_nettype none

interface pbfa_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [pbfa_pkg::INDEX_W-1:0]  index;
	logic [pbfa_pkg::VALUE_W-1:0]  write_value;

	modport source (output valid, func, index, write_value, input ready);
	modport sink (input valid, func, index, write_value, output ready);
endinterface

interface pbfa_out_if;
	logic                          valid;
	logic                          ready;
	logic [pbfa_pkg::VALUE_W-1:0]  read_value;
	logic                          index_error;

	modport source (output valid, read_value, index_error, input ready);
	modport sink (input valid, read_value, index_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/pbfa_store.sv */
// byte-wide store with one write port and one registered read port
`default_nettype none

module pbfa_store (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [pbfa_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                  wdata,
	input  wire logic [pbfa_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                       rdata
);

	logic [7:0] mem [pbfa_pkg::STORE_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/pbfa_lane.sv */
// byte-serial lane: per-byte mask, merge of write digits and gather of read digits
`default_nettype none

module pbfa_lane (
	input  wire logic                         clk,
	input  wire pbfa_pkg::lane_ctrl_t         ctrl,
	input  wire logic [pbfa_pkg::WIDTH_W-1:0] width,
	input  wire logic [2:0]                   offset,
	input  wire logic [pbfa_pkg::VALUE_W-1:0] value,
	input  wire logic [7:0]                   rdata,
	output logic                              we,
	output logic [7:0]                        wdata,
	output logic [pbfa_pkg::WIN_W-1:0]        rwin
);

	logic [pbfa_pkg::WIDTH_W-1:0] bits_left_q;
	logic                         first_q;
	logic [pbfa_pkg::WIN_W-1:0]   vwin_q;
	logic [pbfa_pkg::WIN_W-1:0]   rwin_q;
	logic [7:0]                   mask_s1;

	logic [2:0] start;
	logic [3:0] avail;
	logic [3:0] cnt;
	logic [7:0] mask;

	// bits of the element that fall into the byte now being issued
	always_comb begin
		start = first_q ? offset : 3'd0;
		avail = 4'd8 - {1'b0, start};
		if (bits_left_q < {3'b000, avail}) begin
			cnt = bits_left_q[3:0];
		end else begin
			cnt = avail;
		end
		if (cnt == 4'd0) begin
			mask = 8'd0;
		end else begin
			mask = 8'(pbfa_pkg::LOW_MASK[3'(cnt - 4'd1)] << start);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bits_left_q <= width;
			first_q     <= 1'b1;
			vwin_q      <= pbfa_pkg::WIN_W'(value) << offset;
		end else begin
			if (ctrl.issue) begin
				bits_left_q <= bits_left_q - pbfa_pkg::WIDTH_W'(cnt);
				first_q     <= 1'b0;
				mask_s1     <= mask;
			end
			if (ctrl.consume) begin
				vwin_q <= {8'd0, vwin_q[pbfa_pkg::WIN_W-1:8]};
				rwin_q <= {rdata & mask_s1, rwin_q[pbfa_pkg::WIN_W-1:8]};
			end
		end
	end

	assign we    = ctrl.consume && ctrl.is_write && (mask_s1 != 8'd0);
	assign wdata = (rdata & ~mask_s1) | (vwin_q[7:0] & mask_s1);
	assign rwin  = rwin_q;

endmodule

`default_nettype wire

/* rtl/core/packed_bit_field_array.sv */
// top level of the packed bit field array
//
// Elements of element_width bits (1..64) are packed LSB-first into a
// byte store. A request on in_ch reads (func 0) or writes (func 1) one
// element by index; every request gives exactly one result on out_ch.
// A read returns the element zero extended; a write returns zero. An
// index at or above element_count, or an element that runs past the
// store, returns index_error with zero data and leaves the store alone.
// Configuration goes in through cfg_we / cfg_index / cfg_data; the
// user must write it only while no request is in flight; the block
// itself does not enforce that. A valid access walks nine
// consecutive bytes, one per cycle, through the one read port and
// the one write port of the store; a refused access skips the walk.
// A new request is taken only once the last result is registered.
// After reset all 4096 bytes of the store are swept to zero, one
// byte a cycle; in_ch.ready stays low during the sweep.
// The result sits in an output register; if out_ch stalls, the block
// finishes at most one more request and then holds it until the
// register drains.
`default_nettype none

module packed_bit_field_array (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [pbfa_pkg::CFG_W-1:0] cfg_data,
	pbfa_in_if.sink                         in_ch,
	pbfa_out_if.source                      out_ch
);

	pbfa_pkg::state_t state_q, state_d;

	logic [pbfa_pkg::WIDTH_W-1:0] cfg_width_q;
	logic [pbfa_pkg::COUNT_W-1:0] cfg_count_q;
	logic [pbfa_pkg::ADDR_W-1:0]  clr_q;
	logic [pbfa_pkg::STEP_W-1:0]  step_q;
	logic                         out_valid_q;

	logic                         func_q;
	logic [pbfa_pkg::INDEX_W-1:0] idx_q;
	logic [pbfa_pkg::VALUE_W-1:0] val_q;
	logic [pbfa_pkg::WIDTH_W-1:0] w_q;
	logic [pbfa_pkg::BASE_W-1:0]  base_q;
	logic                         err_q;
	logic [pbfa_pkg::ADDR_W-1:0]  addr_q;
	logic [pbfa_pkg::ADDR_W-1:0]  waddr_s1;
	logic [pbfa_pkg::VALUE_W-1:0] read_value_q;
	logic                         index_error_q;

	logic [pbfa_pkg::WIDTH_W-1:0] w_eff;
	logic [pbfa_pkg::LAST_W-1:0]  last_bit;
	logic [pbfa_pkg::LBYTE_W-1:0] last_byte;
	logic                         err_d;
	logic                         accept;
	logic                         out_free;
	logic                         last_step;

	pbfa_pkg::lane_ctrl_t        lane_ctrl;
	logic                        lane_we;
	logic [7:0]                  lane_wdata;
	logic [pbfa_pkg::WIN_W-1:0]  lane_rwin;
	logic [pbfa_pkg::WIN_W-1:0]  rwin_aligned;

	logic                        st_we;
	logic [pbfa_pkg::ADDR_W-1:0] st_waddr;
	logic [7:0]                  st_wdata;
	logic [7:0]                  st_rdata;

	// width zero acts as one, above 64 saturates
	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = pbfa_pkg::WIDTH_W'(1);
		end else if (cfg_width_q > pbfa_pkg::WIDTH_W'(pbfa_pkg::VALUE_W)) begin
			w_eff = pbfa_pkg::WIDTH_W'(pbfa_pkg::VALUE_W);
		end else begin
			w_eff = cfg_width_q;
		end
	end

	assign last_bit  = pbfa_pkg::LAST_W'(base_q) + pbfa_pkg::LAST_W'(w_q)
		- pbfa_pkg::LAST_W'(1);
	assign last_byte = last_bit[pbfa_pkg::LAST_W-1:3];
	assign err_d     = ({1'b0, idx_q} >= cfg_count_q)
		|| (last_byte >= pbfa_pkg::LBYTE_W'(pbfa_pkg::STORE_BYTES));

	assign accept    = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign last_step = (step_q == pbfa_pkg::STEP_W'(pbfa_pkg::SPAN));

	always_comb begin
		state_d              = state_q;
		in_ch.ready          = 1'b0;
		lane_ctrl.load       = 1'b0;
		lane_ctrl.issue      = 1'b0;
		lane_ctrl.consume    = 1'b0;
		lane_ctrl.is_write   = (func_q == pbfa_pkg::FUNC_WRITE);
		unique case (state_q)
			pbfa_pkg::ST_CLEAR: begin
				if (clr_q == pbfa_pkg::ADDR_W'(pbfa_pkg::STORE_BYTES - 1)) begin
					state_d = pbfa_pkg::ST_IDLE;
				end
			end
			pbfa_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = pbfa_pkg::ST_MUL;
				end
			end
			pbfa_pkg::ST_MUL: begin
				state_d = pbfa_pkg::ST_CHK;
			end
			pbfa_pkg::ST_CHK: begin
				lane_ctrl.load = 1'b1;
				state_d = err_d ? pbfa_pkg::ST_FIN : pbfa_pkg::ST_RUN;
			end
			pbfa_pkg::ST_RUN: begin
				lane_ctrl.issue   = !last_step;
				lane_ctrl.consume = (step_q != '0);
				if (last_step) begin
					state_d = pbfa_pkg::ST_FIN;
				end
			end
			pbfa_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = pbfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbfa_pkg::ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			cfg_width_q <= pbfa_pkg::WIDTH_W'(8);
			cfg_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pbfa_pkg::ST_CLEAR) begin
				clr_q <= clr_q + pbfa_pkg::ADDR_W'(1);
			end
			if (state_q == pbfa_pkg::ST_CHK) begin
				step_q <= '0;
			end else if (state_q == pbfa_pkg::ST_RUN && !last_step) begin
				step_q <= step_q + pbfa_pkg::STEP_W'(1);
			end
			if (state_q == pbfa_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					pbfa_pkg::REG_WIDTH: cfg_width_q <= cfg_data[pbfa_pkg::WIDTH_W-1:0];
					pbfa_pkg::REG_COUNT: cfg_count_q <= cfg_data[pbfa_pkg::COUNT_W-1:0];
				endcase
			end
		end
	end

	assign rwin_aligned = lane_rwin >> base_q[2:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_ch.func;
			idx_q  <= in_ch.index;
			val_q  <= in_ch.write_value;
			w_q    <= w_eff;
		end
		if (state_q == pbfa_pkg::ST_MUL) begin
			base_q <= pbfa_pkg::BASE_W'(idx_q) * pbfa_pkg::BASE_W'(w_q);
		end
		if (state_q == pbfa_pkg::ST_CHK) begin
			err_q  <= err_d;
			addr_q <= pbfa_pkg::ADDR_W'(base_q >> 3);
		end
		if (lane_ctrl.issue) begin
			addr_q   <= addr_q + pbfa_pkg::ADDR_W'(1);
			waddr_s1 <= addr_q;
		end
		if (state_q == pbfa_pkg::ST_FIN && out_free) begin
			index_error_q <= err_q;
			if (err_q || func_q == pbfa_pkg::FUNC_WRITE) begin
				read_value_q <= '0;
			end else begin
				read_value_q <= rwin_aligned[pbfa_pkg::VALUE_W-1:0];
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.read_value  = read_value_q;
	assign out_ch.index_error = index_error_q;

	pbfa_lane u_lane (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.width  (w_q),
		.offset (base_q[2:0]),
		.value  (val_q),
		.rdata  (st_rdata),
		.we     (lane_we),
		.wdata  (lane_wdata),
		.rwin   (lane_rwin)
	);

	// the clearing sweep owns the write port until it ends
	assign st_we    = (state_q == pbfa_pkg::ST_CLEAR) || lane_we;
	assign st_waddr = (state_q == pbfa_pkg::ST_CLEAR) ? clr_q : waddr_s1;
	assign st_wdata = (state_q == pbfa_pkg::ST_CLEAR) ? 8'd0 : lane_wdata;

	pbfa_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (addr_q),
		.rdata (st_rdata)
	);

	a_store_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == pbfa_pkg::ST_CLEAR || state_q == pbfa_pkg::ST_RUN))
		else $error("store written outside clear sweep or byte walk");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.index_error |-> out_ch.read_value == '0)
		else $error("refused access returned data");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbfa_pkg::ST_RUN && last_step |=> state_q == pbfa_pkg::ST_FIN)
		else $error("byte walk did not end after nine bytes");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbfa_pkg::ST_RUN |-> step_q <= pbfa_pkg::STEP_W'(pbfa_pkg::SPAN))
		else $error("byte step counter out of range");

endmodule

`default_nettype wire
